// ===== design/imubpp_pkg.sv =====
// ----------------------------------------------------------------------------
// imubpp_pkg
// Shared types and constants for the binary sensor packet parser.
// ----------------------------------------------------------------------------
package imubpp_pkg;

	localparam int unsigned FrameLastPos = 43;
	localparam int unsigned DataFirstPos = 6;
	localparam int unsigned DataLastPos  = 41;
	localparam int unsigned CrcLoPos     = 42;
	localparam int unsigned WordCount    = 9;
	localparam int unsigned WordIdxW     = $clog2(WordCount);
	localparam int unsigned PosW         = 6;
	localparam int unsigned CfgIdxW      = 8;
	localparam int unsigned CfgDataW     = 16;

	localparam logic [7:0]  SyncReset  = 8'hFA;
	localparam logic [7:0]  GroupReset = 8'h14;
	localparam logic [15:0] ImuReset   = 16'h0018;
	localparam logic [15:0] AttReset   = 16'h0002;

	localparam logic [CfgIdxW-1:0] RegSync  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] RegGroup = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] RegImu   = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] RegAtt   = CfgIdxW'(3);

	typedef struct packed {
		logic [7:0]  sync_value;
		logic [7:0]  group_value;
		logic [15:0] imu_mask;
		logic [15:0] attitude_mask;
	} cfg_t;

	// what the back end has to do with one frame byte
	typedef enum logic [1:0] {
		CLS_HEADER,
		CLS_WORD,
		CLS_CRC_LO,
		CLS_CRC_HI
	} cls_t;

	typedef struct packed {
		cls_t                cls;
		logic [7:0]          data;
		logic [WordIdxW-1:0] word;
		logic [1:0]          lane;
		logic                hdr_ok;
	} beat_t;

endpackage

// ===== design/imubpp_front.sv =====
// ----------------------------------------------------------------------------
// imubpp_front
// Sync hunt, frame position tracking, header checks and byte classification.
// ----------------------------------------------------------------------------
module imubpp_front
	import imubpp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  accept,
	input  logic  [7:0] rx_byte,
	output logic  push,
	output beat_t push_beat
);

	logic [PosW-1:0] pos_q;
	logic            hdr_good_q;
	logic            hdr_match;
	logic [PosW-1:0] k;

	assign k = pos_q - PosW'(DataFirstPos);

	always_comb begin
		priority case (pos_q)
			PosW'(1): hdr_match = (rx_byte == cfg.group_value);
			PosW'(2): hdr_match = (rx_byte == cfg.imu_mask[7:0]);
			PosW'(3): hdr_match = (rx_byte == cfg.imu_mask[15:8]);
			PosW'(4): hdr_match = (rx_byte == cfg.attitude_mask[7:0]);
			PosW'(5): hdr_match = (rx_byte == cfg.attitude_mask[15:8]);
			default:  hdr_match = 1'b1;
		endcase
	end

	always_comb begin
		push_beat.data   = rx_byte;
		push_beat.word   = k[WordIdxW+1:2];
		push_beat.lane   = k[1:0];
		push_beat.hdr_ok = hdr_good_q;
		if (pos_q < PosW'(DataFirstPos)) begin
			push_beat.cls = CLS_HEADER;
		end else if (pos_q <= PosW'(DataLastPos)) begin
			push_beat.cls = CLS_WORD;
		end else if (pos_q == PosW'(CrcLoPos)) begin
			push_beat.cls = CLS_CRC_LO;
		end else begin
			push_beat.cls = CLS_CRC_HI;
		end
	end

	// idle bytes are dropped here, never queued
	assign push = accept && (pos_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			hdr_good_q <= 1'b1;
		end else if (accept) begin
			if (pos_q == '0) begin
				if (rx_byte == cfg.sync_value) begin
					pos_q      <= PosW'(1);
					hdr_good_q <= 1'b1;
				end
			end else begin
				hdr_good_q <= hdr_good_q && hdr_match;
				if (pos_q == PosW'(FrameLastPos)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + PosW'(1);
				end
			end
		end
	end

endmodule

// ===== design/imubpp_fifo.sv =====
// ----------------------------------------------------------------------------
// imubpp_fifo
// Two-entry queue of classified beats between front and back end.
// ----------------------------------------------------------------------------
module imubpp_fifo
	import imubpp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  beat_t push_beat,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output beat_t head
);

	beat_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/imubpp_back.sv =====
// ----------------------------------------------------------------------------
// imubpp_back
// CRC-16/XMODEM, frame word assembly, latest good values and result register.
// ----------------------------------------------------------------------------
module imubpp_back
	import imubpp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  beat_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_ok,
	output logic [31:0] latest [WordCount],
	output logic        have_data
);

	logic [15:0] crc_q;
	logic [7:0]  crc_lo_q;
	logic [31:0] words_q  [WordCount];
	logic [31:0] latest_q [WordCount];
	logic        have_q;
	logic        ok_q;
	logic        out_valid_q;
	logic        out_free;
	logic        is_end;
	logic        crc_match;
	logic        ok;

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = {c[7:0], c[15:8]} ^ {8'h00, b};
		x = x ^ {12'h000, x[7:4]};
		x = x ^ {x[3:0], 12'h000};
		x = x ^ {3'b000, x[7:0], 5'b00000};
		return x;
	endfunction

	assign out_free  = !out_valid_q || !out_stall;
	assign is_end    = (head.cls == CLS_CRC_HI);
	// an end beat waits until the result register can take it
	assign pop       = head_valid && (!is_end || out_free);
	assign crc_match = (crc_q == {head.data, crc_lo_q});
	assign ok        = head.hdr_ok && crc_match;

	assign out_valid = out_valid_q;
	assign frame_ok  = ok_q;
	assign latest    = latest_q;
	assign have_data = have_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.cls == CLS_WORD) begin
				words_q[head.word][{head.lane, 3'b000} +: 8] <= head.data;
			end
			if (head.cls == CLS_CRC_LO) begin
				crc_lo_q <= head.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			have_q      <= 1'b0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WordCount; i++) begin
				latest_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (head.cls)
					CLS_HEADER, CLS_WORD: begin
						crc_q <= crc_step(crc_q, head.data);
					end
					CLS_CRC_LO: begin
						crc_q <= crc_q;
					end
					CLS_CRC_HI: begin
						crc_q       <= '0;
						ok_q        <= ok;
						out_valid_q <= 1'b1;
						if (ok) begin
							have_q   <= 1'b1;
							latest_q <= words_q;
						end
					end
					default: begin
						crc_q <= crc_q;
					end
				endcase
			end
		end
	end

endmodule

// ===== design/imu_binary_packet_parser_core.sv =====
// ----------------------------------------------------------------------------
// imu_binary_packet_parser_core
// Sync-framed 44-byte sensor packet parser with header and CRC-16 check.
// ----------------------------------------------------------------------------
// channel   handshake                fields
// input     in_valid / in_stall      rx_byte
// output    out_valid / out_stall    frame_ok, 9 float words, have_data
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one byte is taken every cycle while in_stall is low; the result of a frame's last
// byte passes through a queue entry, then the result register, to the output.
// in_stall rises only when the two-entry queue is full: a frame's last byte waits
// at the head behind a stalled result and one more frame byte lands behind it.
// reset returns to sync hunt with register defaults and zeroed latest values.
// ----------------------------------------------------------------------------
module imu_binary_packet_parser_core
	import imubpp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                frame_ok,
	output logic [31:0]         accel_x,
	output logic [31:0]         accel_y,
	output logic [31:0]         accel_z,
	output logic [31:0]         rate_x,
	output logic [31:0]         rate_y,
	output logic [31:0]         rate_z,
	output logic [31:0]         yaw_word,
	output logic [31:0]         pitch_word,
	output logic [31:0]         roll_word,
	output logic                have_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t        cfg_q;
	logic        accept;
	logic        push;
	beat_t       push_beat;
	logic        full;
	logic        pop;
	logic        head_valid;
	beat_t       head;
	logic [31:0] latest [WordCount];

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_value    <= SyncReset;
			cfg_q.group_value   <= GroupReset;
			cfg_q.imu_mask      <= ImuReset;
			cfg_q.attitude_mask <= AttReset;
		end else if (cfg_valid && cfg_ready) begin
			priority case (cfg_index)
				RegSync:  cfg_q.sync_value    <= cfg_data[7:0];
				RegGroup: cfg_q.group_value   <= cfg_data[7:0];
				RegImu:   cfg_q.imu_mask      <= cfg_data;
				RegAtt:   cfg_q.attitude_mask <= cfg_data;
				default:  cfg_q               <= cfg_q;
			endcase
		end
	end

	imubpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.push      (push),
		.push_beat (push_beat)
	);

	imubpp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_beat  (push_beat),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	imubpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_ok   (frame_ok),
		.latest     (latest),
		.have_data  (have_data)
	);

	assign accel_x    = latest[0];
	assign accel_y    = latest[1];
	assign accel_z    = latest[2];
	assign rate_x     = latest[3];
	assign rate_y     = latest[4];
	assign rate_z     = latest[5];
	assign yaw_word   = latest[6];
	assign pitch_word = latest[7];
	assign roll_word  = latest[8];

endmodule
